FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the minimum-image distance block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk_s, rst_s, expr, msg) \
  `ASSERT_CLK(label, clk_s, rst_s, !(expr), msg)

`endif

FILE: rtl/imgd_pkg.sv
// Package of the minimum-image distance block: widths, payload types and
// register indexes. Depends on nothing.
package imgd_pkg;

  localparam int COORD_BITS = 24;
  localparam int SEP_W      = COORD_BITS + 1;
  localparam int SGN_W      = COORD_BITS + 2;
  localparam int MAG_W      = COORD_BITS + 1;
  localparam int CMP_W      = (MAG_W > 32) ? MAG_W : 32;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ITER       = SUM_W / 2;
  localparam int REM_W      = ITER + 2;
  localparam int AXIS_ST    = 4;
  localparam int NST        = AXIS_ST + ITER + 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CMP_W-1:0] OFFSET_CLAMP = CMP_W'(64'h8000_0000);

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [SEP_W-1:0]        sep_t;
  typedef logic signed [SGN_W-1:0] sgn_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic [SQ_W-1:0]         sq_t;
  typedef logic [SUM_W-1:0]        sum_t;
  typedef logic [ITER-1:0]         root_t;
  typedef logic [REM_W-1:0]        rem_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [AXIS_ST-1:0]      axis_en_t;
  typedef logic [ITER-1:0]         sqrt_en_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_X = 2'd0,
    REG_BOX_Y = 2'd1,
    REG_BOX_Z = 2'd2
  } reg_idx_t;

endpackage

FILE: rtl/imgd_if.sv
// Channel interfaces of the minimum-image distance block: point pairs in,
// separations out. Depends on imgd_pkg.
interface imgd_in_if;
  logic             valid;
  logic             ready;
  imgd_pkg::coord_t first_x;
  imgd_pkg::coord_t first_y;
  imgd_pkg::coord_t first_z;
  imgd_pkg::coord_t second_x;
  imgd_pkg::coord_t second_y;
  imgd_pkg::coord_t second_z;

  modport source(output valid, first_x, first_y, first_z, second_x, second_y,
                 second_z, input ready);
  modport sink(input valid, first_x, first_y, first_z, second_x, second_y,
               second_z, output ready);
endinterface

interface imgd_out_if;
  logic           valid;
  logic           ready;
  imgd_pkg::sep_t separation;

  modport source(output valid, separation, input ready);
  modport sink(input valid, separation, output ready);
endinterface

FILE: rtl/imgd_axis.sv
// Per-axis front end: shift, single wrap, clamped offset magnitude and its
// square, in four register stages. Depends on imgd_pkg.
module imgd_axis (
  input  logic               clk,
  input  imgd_pkg::axis_en_t en,
  input  imgd_pkg::coord_t   ref_c,
  input  imgd_pkg::coord_t   oth_c,
  input  imgd_pkg::coord_t   box_len,
  output imgd_pkg::sq_t      sq
);
  import imgd_pkg::*;

  sgn_t moved_r, moved_nxt;
  sgn_t wrap_r, wrap_nxt;
  mag_t mag_r, mag_nxt;
  sq_t  sq_r;
  sgn_t half_s, box_s, off;
  logic [CMP_W-1:0] mag_wide;

  assign half_s = sgn_t'({1'b0, box_len[COORD_BITS-1:1]});
  assign box_s  = sgn_t'(box_len);

  assign moved_nxt = sgn_t'(oth_c) + half_s - sgn_t'(ref_c);

  always_comb begin
    if (moved_r > box_s) begin
      wrap_nxt = moved_r - box_s;
    end else if (moved_r < 0) begin
      wrap_nxt = moved_r + box_s;
    end else begin
      wrap_nxt = moved_r;
    end
  end

  always_comb begin
    off = half_s - wrap_r;
    if (off < 0) begin
      mag_wide = CMP_W'(MAG_W'(-off));
    end else begin
      mag_wide = CMP_W'(MAG_W'(off));
    end
    if (mag_wide > OFFSET_CLAMP) begin
      mag_nxt = MAG_W'(OFFSET_CLAMP);
    end else begin
      mag_nxt = MAG_W'(mag_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      moved_r <= moved_nxt;
    end
    if (en[1]) begin
      wrap_r <= wrap_nxt;
    end
    if (en[2]) begin
      mag_r <= mag_nxt;
    end
    if (en[3]) begin
      sq_r <= mag_r * mag_r;
    end
  end

  assign sq = sq_r;

endmodule

FILE: rtl/imgd_sqrt.sv
// Pipelined floor square root, one result bit per register stage by the
// restoring digit recurrence. Depends on imgd_pkg.
module imgd_sqrt (
  input  logic               clk,
  input  imgd_pkg::sqrt_en_t en,
  input  imgd_pkg::sum_t     radicand,
  output imgd_pkg::root_t    root
);
  import imgd_pkg::*;

  rem_t  rem_r  [ITER];
  root_t root_r [ITER];
  sum_t  rad_r  [ITER];

  for (genvar k = 0; k < ITER; k++) begin : g_step
    rem_t  rem_prev, rem_try, trial;
    root_t root_prev;
    sum_t  rad_prev;

    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = radicand;
    end else begin : g_next
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
      assign rad_prev  = rad_r[k-1];
    end

    assign rem_try = {rem_prev[REM_W-3:0], rad_prev[SUM_W-1 -: 2]};
    assign trial   = {root_prev, 2'b01};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rad_r[k] <= {rad_prev[SUM_W-3:0], 2'b00};
        if (rem_try >= trial) begin
          rem_r[k]  <= rem_try - trial;
          root_r[k] <= {root_prev[ITER-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_try;
          root_r[k] <= {root_prev[ITER-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[ITER-1];

endmodule

FILE: rtl/periodic_min_image_distance_core.sv
// Top level of the periodic minimum-image distance block.
// Depends on imgd_pkg, imgd_if, imgd_axis, imgd_sqrt and assert_macros.svh.
//
// Usage: each transfer on in_ch carries two 3-D points (Q16.8 coordinates);
// one transfer on out_ch later carries their minimum-image separation as an
// unsigned Q17.8 value, floor of the true distance, in input order.
// Box edges are set through cfg_we, cfg_index and cfg_wdata, one register
// per write with index 0, 1, 2 for x, y, z; other indexes are ignored.
// Write them only while no pair is in flight.
// The pipeline has four stages per axis, one adder stage, one stage per root
// bit of the square-root recurrence and one output register.
// Throughput is one pair per cycle while out_ch.ready stays high; every stage
// has its own valid bit.
// When out_ch.ready is low, the output holds its value and the stages behind
// it keep filling empty slots; in_ch.ready falls only when every stage holds
// a pair. Reset empties the pipeline and sets each box edge to all ones.
`include "assert_macros.svh"

module periodic_min_image_distance_core (
  input  logic                 clk,
  input  logic                 rst_n,
  imgd_in_if.sink              in_ch,
  imgd_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  imgd_pkg::cfg_idx_t   cfg_index,
  input  imgd_pkg::coord_t     cfg_wdata
);
  import imgd_pkg::*;

  coord_t box_x_r, box_y_r, box_z_r;
  logic [NST-1:0] v_r, v_nxt, en;
  sq_t    sq_x, sq_y, sq_z;
  sum_t   sum_r;
  root_t  root;
  sep_t   sep_r, sep_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= '1;
      box_y_r <= '1;
      box_z_r <= '1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BOX_X: begin
          box_x_r <= cfg_wdata;
        end
        REG_BOX_Y: begin
          box_y_r <= cfg_wdata;
        end
        REG_BOX_Z: begin
          box_z_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ch.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_ch.valid;
    end
    for (int i = 1; i < NST; i++) begin
      if (en[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  imgd_axis u_axis_x (
    .clk     (clk),
    .en      (en[AXIS_ST-1:0]),
    .ref_c   (in_ch.first_x),
    .oth_c   (in_ch.second_x),
    .box_len (box_x_r),
    .sq      (sq_x)
  );

  imgd_axis u_axis_y (
    .clk     (clk),
    .en      (en[AXIS_ST-1:0]),
    .ref_c   (in_ch.first_y),
    .oth_c   (in_ch.second_y),
    .box_len (box_y_r),
    .sq      (sq_y)
  );

  imgd_axis u_axis_z (
    .clk     (clk),
    .en      (en[AXIS_ST-1:0]),
    .ref_c   (in_ch.first_z),
    .oth_c   (in_ch.second_z),
    .box_len (box_z_r),
    .sq      (sq_z)
  );

  always_ff @(posedge clk) begin
    if (en[AXIS_ST]) begin
      sum_r <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
    end
  end

  imgd_sqrt u_sqrt (
    .clk      (clk),
    .en       (en[AXIS_ST+ITER:AXIS_ST+1]),
    .radicand (sum_r),
    .root     (root)
  );

  always_comb begin
    if (root > {{(ITER-SEP_W){1'b0}}, {SEP_W{1'b1}}}) begin
      sep_nxt = '1;
    end else begin
      sep_nxt = root[SEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      sep_r <= sep_nxt;
    end
  end

  assign in_ch.ready       = en[0];
  assign out_ch.valid      = v_r[NST-1];
  assign out_ch.separation = sep_r;

  `ASSERT_CLK(a_block_only_full, clk, rst_n, !in_ch.ready |-> (&v_r),
    "input blocked while the pipeline has an empty stage")
  `ASSERT_CLK(a_drain_empty, clk, rst_n,
    (out_ch.valid && out_ch.ready && !v_r[NST-2]) |=> !out_ch.valid,
    "result repeated after the output transfer")
  `ASSERT_NEVER(a_count_step, clk, rst_n,
    $countones(v_r) > $past($countones(v_r)) + 1,
    "more than one item entered the pipeline in a cycle")

endmodule
